// File: design/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, sizes and codes for the scanline triangle fill block.
// ----------------------------------------------------------------------------
package tsf_pkg;

    // grid geometry
    localparam int GRID_W    = 256;
    localparam int GRID_H    = 256;
    localparam int CELL_BITS = 8;
    localparam int COL_W     = $clog2(GRID_W);
    localparam int ROW_W     = $clog2(GRID_H);
    localparam int DEPTH     = GRID_W * GRID_H;
    localparam int ADDR_W    = $clog2(DEPTH);

    // datapath widths
    localparam int COORD_W   = 16;   // Q12.4 coordinate
    localparam int DIFF_W    = 17;   // difference of two coordinates
    localparam int YROW_W    = 13;   // signed integer row
    localparam int ACC_W     = 45;   // Q16.16 edge accumulator with stepping headroom
    localparam int SLOPE_W   = 32;   // Q16.16 inverse slope
    localparam int XCOL_W    = 30;   // integer column from an accumulator
    localparam int CHK_W     = 14;   // unsigned range checks against grid sizes

    // divider
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // input op codes
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        CMD_FB,
        CMD_FT,
        CMD_SPLIT,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    // classified command, vertices already sorted by y
    typedef struct packed {
        cmd_kind_t              kind;
        coord_t                 x0;
        coord_t                 y0;
        coord_t                 x1;
        coord_t                 y1;
        coord_t                 x2;
        coord_t                 y2;
        logic [CELL_BITS-1:0]   val;
        logic [7:0]             col;
        logic [7:0]             row;
    } cmd_t;

    typedef struct packed {
        logic                   start;
        logic [DIV_NUM_W-1:0]   num;
        logic [DIV_DEN_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [DIV_NUM_W-1:0]   quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_RDATA,
        BK_MUL,
        BK_DIV_GO,
        BK_DIV_WAIT,
        BK_PART,
        BK_ROW,
        BK_SPAN
    } back_state_t;

    typedef enum logic [1:0] {
        DS_X4,
        DS_S1,
        DS_S2
    } div_sel_t;

endpackage

// File: design/tsf_front.sv
// ----------------------------------------------------------------------------
// tsf_front
// Accepts words, sorts triangle vertices by y and classifies each word.
// ----------------------------------------------------------------------------
module tsf_front import tsf_pkg::*; (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic signed [15:0]    s_ax,
    input  logic signed [15:0]    s_ay,
    input  logic signed [15:0]    s_bx,
    input  logic signed [15:0]    s_by_coord,
    input  logic signed [15:0]    s_cx,
    input  logic signed [15:0]    s_cy,
    input  logic [7:0]            s_fill_value,
    input  logic [7:0]            s_read_col,
    input  logic [7:0]            s_read_row,
    input  logic                  queue_full,
    input  logic                  init_busy,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic  known_op;

    // stable three-element insertion sort on y, then classification
    always_comb begin
        coord_t px0, py0, px1, py1, px2, py2, t;
        px0 = s_ax; py0 = s_ay;
        px1 = s_bx; py1 = s_by_coord;
        px2 = s_cx; py2 = s_cy;
        if (py0 > py1) begin
            t = px0; px0 = px1; px1 = t;
            t = py0; py0 = py1; py1 = t;
        end
        if (py1 > py2) begin
            t = px1; px1 = px2; px2 = t;
            t = py1; py1 = py2; py2 = t;
        end
        if (py0 > py1) begin
            t = px0; px0 = px1; px1 = t;
            t = py0; py0 = py1; py1 = t;
        end
        push_cmd.x0  = px0;
        push_cmd.y0  = py0;
        push_cmd.x1  = px1;
        push_cmd.y1  = py1;
        push_cmd.x2  = px2;
        push_cmd.y2  = py2;
        push_cmd.val = CELL_BITS'(s_fill_value);
        push_cmd.col = s_read_col;
        push_cmd.row = s_read_row;
        known_op     = 1'b1;
        case (s_op)
            OP_DRAW: begin
                if (py1 == py2) begin
                    push_cmd.kind = CMD_FB;
                end else if (py0 == py1) begin
                    push_cmd.kind = CMD_FT;
                end else begin
                    push_cmd.kind = CMD_SPLIT;
                end
            end
            OP_READ:  push_cmd.kind = CMD_READ;
            OP_CLEAR: push_cmd.kind = CMD_CLEAR;
            default: begin
                push_cmd.kind = CMD_READ;
                known_op      = 1'b0;
            end
        endcase
    end

    // unknown ops are taken and dropped
    assign s_ready = !queue_full && !init_busy;
    assign push    = s_valid && s_ready && known_op;

endmodule

// File: design/tsf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tsf_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tsf_cmd_fifo import tsf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  cmd_t   push_cmd,
    output logic   full,
    input  logic   pop,
    output cmd_t   pop_cmd,
    output logic   avail
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign avail   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsf_div import tsf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic [DIV_DEN_W:0]    shift_rem;
    logic [DIV_DEN_W:0]    diff;
    logic                  ge;

    // one trial subtraction
    always_comb begin
        shift_rem = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge        = (shift_rem >= {1'b0, den_reg});
        diff      = shift_rem - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : shift_rem[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// File: design/tsf_back.sv
// ----------------------------------------------------------------------------
// tsf_back
// Command engine: grid memory, clears, slope setup, row stepping, span writes, reads.
// ----------------------------------------------------------------------------
module tsf_back import tsf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_avail,
    input  cmd_t        cmd_in,
    output logic        cmd_pop,
    output logic        init_busy,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cell_value
);

    back_state_t                 state_reg, state_next;
    cmd_t                        cmd_reg;
    logic [CELL_BITS-1:0]        wval_reg;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic                        init_reg;
    logic                        part_reg;
    div_sel_t                    sel_reg;
    logic [DIV_NUM_W-1:0]        prod_reg;
    logic                        prod_neg_reg;
    coord_t                      x4_reg;
    coord_t                      pax_reg, pay_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic                        down_reg;
    logic signed [YROW_W-1:0]    row_reg;
    logic signed [ACC_W-1:0]     acc1_reg, acc2_reg;
    logic signed [SLOPE_W-1:0]   slope1_reg, slope2_reg;
    logic [COL_W-1:0]            col_reg, hi_reg;
    logic [ROW_W-1:0]            srow_reg;
    logic                        rd_zero_reg;
    logic [CELL_BITS-1:0]        mem_rd_reg;
    logic                        m_valid_reg;
    logic [7:0]                  m_value_reg;
    logic [CELL_BITS-1:0]        grid_mem [DEPTH];

    function automatic logic [DIV_DEN_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] n;
        n = d[DIFF_W-1] ? -d : d;
        return n[DIV_DEN_W-1:0];
    endfunction

    function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic [DIV_NUM_W-1:0] q,
                                                            input logic neg);
        logic signed [SLOPE_W-1:0] r;
        if (!neg) begin
            r = q[DIV_NUM_W-1] ? {1'b0, {(SLOPE_W-1){1'b1}}} : q;
        end else begin
            r = (q > {1'b1, {(DIV_NUM_W-1){1'b0}}}) ? {1'b1, {(SLOPE_W-1){1'b0}}} : -q;
        end
        return r;
    endfunction

    function automatic logic signed [XCOL_W-1:0] trunc_col(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] adj;
        logic signed [ACC_W-1:0] sh;
        adj = a + (a[ACC_W-1] ? {{(ACC_W-16){1'b0}}, 16'hFFFF} : '0);
        sh  = adj >>> 16;
        return sh[XCOL_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // divider operand selection
    logic signed [DIFF_W-1:0]  dx1, dy1, dx2, dy2, dy02, dx02, dy01;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_neg;
    logic signed [SLOPE_W-1:0] slope_res;
    logic signed [DIFF_W-1:0]  q_small, x4_sum;

    always_comb begin
        if (down_reg) begin
            dx1 = DIFF_W'(pax_reg) - DIFF_W'(e1x_reg);
            dy1 = DIFF_W'(pay_reg) - DIFF_W'(e1y_reg);
            dx2 = DIFF_W'(pax_reg) - DIFF_W'(e2x_reg);
            dy2 = DIFF_W'(pay_reg) - DIFF_W'(e2y_reg);
        end else begin
            dx1 = DIFF_W'(e1x_reg) - DIFF_W'(pax_reg);
            dy1 = DIFF_W'(e1y_reg) - DIFF_W'(pay_reg);
            dx2 = DIFF_W'(e2x_reg) - DIFF_W'(pax_reg);
            dy2 = DIFF_W'(e2y_reg) - DIFF_W'(pay_reg);
        end
        dy02 = DIFF_W'(cmd_reg.y2) - DIFF_W'(cmd_reg.y0);
        dx02 = DIFF_W'(cmd_reg.x2) - DIFF_W'(cmd_reg.x0);
        dy01 = DIFF_W'(cmd_reg.y1) - DIFF_W'(cmd_reg.y0);
        case (sel_reg)
            DS_X4: begin
                div_num = prod_reg;
                div_den = mag(dy02);
                div_neg = prod_neg_reg;
            end
            DS_S1: begin
                div_num = {mag(dx1), 16'h0000};
                div_den = mag(dy1);
                div_neg = dx1[DIFF_W-1] ^ dy1[DIFF_W-1];
            end
            default: begin
                div_num = {mag(dx2), 16'h0000};
                div_den = mag(dy2);
                div_neg = dx2[DIFF_W-1] ^ dy2[DIFF_W-1];
            end
        endcase
        slope_res = (div_den == '0) ? '0 : sat_slope(div_rsp.quo, div_neg);
        q_small   = $signed({1'b0, div_rsp.quo[DIV_DEN_W-1:0]});
        x4_sum    = DIFF_W'(cmd_reg.x0) + (div_neg ? -q_small : q_small);
    end

    // ---------------------------------------------------------------------
    // part setup: apex and the two far edge ends
    logic   setup_fb;
    coord_t n_pax, n_pay, n_e1x, n_e1y, n_e2x, n_e2y;
    logic signed [DIFF_W-1:0] yadj, yrow;

    always_comb begin
        setup_fb = (cmd_reg.kind == CMD_FB) || ((cmd_reg.kind == CMD_SPLIT) && !part_reg);
        if (setup_fb) begin
            n_pax = cmd_reg.x0; n_pay = cmd_reg.y0;
            n_e1x = cmd_reg.x1; n_e1y = cmd_reg.y1;
            if (cmd_reg.kind == CMD_FB) begin
                n_e2x = cmd_reg.x2; n_e2y = cmd_reg.y2;
            end else begin
                n_e2x = x4_reg; n_e2y = cmd_reg.y1;
            end
        end else begin
            n_pax = cmd_reg.x2; n_pay = cmd_reg.y2;
            if (cmd_reg.kind == CMD_FT) begin
                n_e1x = cmd_reg.x0; n_e1y = cmd_reg.y0;
                n_e2x = cmd_reg.x1; n_e2y = cmd_reg.y1;
            end else begin
                n_e1x = cmd_reg.x1; n_e1y = cmd_reg.y1;
                n_e2x = x4_reg;     n_e2y = cmd_reg.y1;
            end
        end
        yadj = DIFF_W'(n_pay) + (n_pay[COORD_W-1] ? DIFF_W'(15) : DIFF_W'(0));
        yrow = yadj >>> 4;
    end

    // ---------------------------------------------------------------------
    // row test and span ends
    logic signed [DIFF_W-1:0]  row16, lim;
    logic                      row_ok, row_in, span_ok;
    logic signed [XCOL_W-1:0]  xa, xb, lo0, hi0, lo, hi;
    logic signed [XCOL_W-1:0]  col_max;

    always_comb begin
        row16   = $signed({row_reg, 4'b0000});
        lim     = DIFF_W'(e1y_reg);
        row_ok  = down_reg ? (row16 > lim) : (row16 <= lim);
        row_in  = !row_reg[YROW_W-1] &&
                  ({1'b0, row_reg} < CHK_W'(GRID_H));
        xa      = trunc_col(acc1_reg);
        xb      = trunc_col(acc2_reg);
        lo0     = (xa < xb) ? xa : xb;
        hi0     = (xa < xb) ? xb : xa;
        col_max = XCOL_W'(GRID_W - 1);
        lo      = lo0[XCOL_W-1] ? '0 : lo0;
        hi      = (hi0 > col_max) ? col_max : hi0;
        span_ok = row_in && (lo <= hi);
    end

    // ---------------------------------------------------------------------
    // read address
    logic              rd_in;
    logic [ADDR_W-1:0] rd_addr, span_addr;

    always_comb begin
        rd_in     = (CHK_W'(cmd_reg.col) < CHK_W'(GRID_W)) &&
                    (CHK_W'(cmd_reg.row) < CHK_W'(GRID_H));
        rd_addr   = ADDR_W'(cmd_reg.row) * ADDR_W'(GRID_W) + ADDR_W'(cmd_reg.col);
        span_addr = ADDR_W'(srow_reg) * ADDR_W'(GRID_W) + ADDR_W'(col_reg);
    end

    // ---------------------------------------------------------------------
    // next state
    logic div_result;
    logic clr_last;

    assign div_result = ((state_reg == BK_DIV_GO) && (div_den == '0)) ||
                        ((state_reg == BK_DIV_WAIT) && div_rsp.done);
    assign clr_last   = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_last) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (cmd_avail) begin
                    case (cmd_in.kind)
                        CMD_FB, CMD_FT: state_next = BK_PART;
                        CMD_SPLIT:      state_next = BK_MUL;
                        CMD_READ:       state_next = BK_READ;
                        CMD_CLEAR:      state_next = BK_CLEAR;
                        default:        state_next = BK_IDLE;
                    endcase
                end
            end
            BK_READ:  state_next = BK_RDATA;
            BK_RDATA: begin
                if (!m_valid_reg || m_ready) state_next = BK_IDLE;
            end
            BK_MUL:   state_next = BK_DIV_GO;
            BK_DIV_GO, BK_DIV_WAIT: begin
                if (div_result) begin
                    case (sel_reg)
                        DS_X4:   state_next = BK_PART;
                        DS_S1:   state_next = BK_DIV_GO;
                        default: state_next = BK_ROW;
                    endcase
                end else begin
                    state_next = BK_DIV_WAIT;
                end
            end
            BK_PART:  state_next = BK_DIV_GO;
            BK_ROW: begin
                if (!row_ok) begin
                    state_next = ((cmd_reg.kind == CMD_SPLIT) && !part_reg) ? BK_PART : BK_IDLE;
                end else if (span_ok) begin
                    state_next = BK_SPAN;
                end
            end
            BK_SPAN: begin
                if (col_reg == hi_reg) state_next = BK_ROW;
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // outputs of the sequencer
    logic              mem_we, mem_re, out_load;
    logic [ADDR_W-1:0] mem_waddr;

    always_comb begin
        cmd_pop       = (state_reg == BK_IDLE) && cmd_avail;
        div_req.start = (state_reg == BK_DIV_GO) && (div_den != '0);
        div_req.num   = div_num;
        div_req.den   = div_den;
        mem_we        = (state_reg == BK_CLEAR) || (state_reg == BK_SPAN);
        mem_waddr     = (state_reg == BK_CLEAR) ? clr_addr_reg : span_addr;
        mem_re        = (state_reg == BK_READ) && rd_in;
        out_load      = (state_reg == BK_RDATA) && (!m_valid_reg || m_ready);
    end

    // ---------------------------------------------------------------------
    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            wval_reg     <= '0;
            init_reg     <= 1'b1;
            part_reg     <= 1'b0;
            sel_reg      <= DS_X4;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_last) init_reg <= 1'b0;
            end
            if (cmd_pop) begin
                clr_addr_reg <= '0;
                part_reg     <= 1'b0;
                if (cmd_in.kind != CMD_READ) wval_reg <= cmd_in.val;
            end
            if (state_reg == BK_MUL)  sel_reg <= DS_X4;
            if (state_reg == BK_PART) sel_reg <= DS_S1;
            if (div_result && (sel_reg == DS_S1)) sel_reg <= DS_S2;
            if ((state_reg == BK_ROW) && !row_ok) part_reg <= 1'b1;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd_pop) cmd_reg <= cmd_in;
        // split vertex product, magnitudes with separate sign
        if (state_reg == BK_MUL) begin
            prod_reg     <= mag(dy01) * mag(dx02);
            prod_neg_reg <= dx02[DIFF_W-1];
        end
        if (div_result) begin
            case (sel_reg)
                DS_X4:   x4_reg     <= x4_sum[COORD_W-1:0];
                DS_S1:   slope1_reg <= slope_res;
                default: slope2_reg <= slope_res;
            endcase
        end
        // new part: apex, edge ends, start row and accumulators
        if (state_reg == BK_PART) begin
            pax_reg  <= n_pax; pay_reg <= n_pay;
            e1x_reg  <= n_e1x; e1y_reg <= n_e1y;
            e2x_reg  <= n_e2x; e2y_reg <= n_e2y;
            down_reg <= !setup_fb;
            row_reg  <= yrow[YROW_W-1:0];
            acc1_reg <= ACC_W'(n_pax) <<< 12;
            acc2_reg <= ACC_W'(n_pax) <<< 12;
        end
        // row step
        if ((state_reg == BK_ROW) && row_ok) begin
            col_reg  <= lo[COL_W-1:0];
            hi_reg   <= hi[COL_W-1:0];
            srow_reg <= row_reg[ROW_W-1:0];
            if (down_reg) begin
                row_reg  <= row_reg - 1'b1;
                acc1_reg <= acc1_reg - ACC_W'(slope1_reg);
                acc2_reg <= acc2_reg - ACC_W'(slope2_reg);
            end else begin
                row_reg  <= row_reg + 1'b1;
                acc1_reg <= acc1_reg + ACC_W'(slope1_reg);
                acc2_reg <= acc2_reg + ACC_W'(slope2_reg);
            end
        end
        if (state_reg == BK_SPAN) col_reg <= col_reg + 1'b1;
        if (state_reg == BK_READ) rd_zero_reg <= !rd_in;
        if (out_load) begin
            m_value_reg <= rd_zero_reg ? 8'h00 : 8'(32'(mem_rd_reg));
        end
    end

    // grid memory
    always_ff @(posedge aclk) begin
        if (mem_we) grid_mem[mem_waddr] <= wval_reg;
        if (mem_re) mem_rd_reg <= grid_mem[rd_addr];
    end

    assign init_busy    = init_reg;
    assign m_valid      = m_valid_reg;
    assign m_cell_value = m_value_reg;

    // ---------------------------------------------------------------------
    // checks
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SPAN) |-> (col_reg <= hi_reg))
        else $error("span column passed its end");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == BK_DIV_WAIT))
        else $error("divider finished while not awaited");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == BK_RDATA))
        else $error("result word without a read");

    a_span_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SPAN) |=> (state_reg == BK_SPAN || state_reg == BK_ROW))
        else $error("span left to an unexpected state");

endmodule

// File: design/triangle_scanline_fill.sv
// ----------------------------------------------------------------------------
// triangle_scanline_fill
// Scanline triangle fill into a 256 x 256 grid of cells with read and clear.
//
//   channel  direction  ports                         word
//   s_       in         s_valid/s_ready + 10 fields   op, three vertices, value
//   m_       out        m_valid/m_ready + cell_value  one per read op
//
// After reset a clearing pass zeroes the grid; s_ready is low meanwhile.
// A clear op holds the back end, writing its value to every cell, one per cycle.
// A read holds it in BK_READ and then BK_RDATA; the result word then waits in its register for m_ready.
// A draw sets up each part with two slope divisions, then steps its rows and writes
// each span cell by cell; a split first divides once more for its fourth vertex.
// The two-entry queue lets up to two words in while the back end is busy.
// ----------------------------------------------------------------------------
module triangle_scanline_fill import tsf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic signed [15:0]  s_ax,
    input  logic signed [15:0]  s_ay,
    input  logic signed [15:0]  s_bx,
    input  logic signed [15:0]  s_by_coord,
    input  logic signed [15:0]  s_cx,
    input  logic signed [15:0]  s_cy,
    input  logic [7:0]          s_fill_value,
    input  logic [7:0]          s_read_col,
    input  logic [7:0]          s_read_row,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_cell_value
);

    logic      push, full, pop, avail, init_busy;
    cmd_t      push_cmd, pop_cmd;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // front: accept and classify
    tsf_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_bx         (s_bx),
        .s_by_coord   (s_by_coord),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .s_fill_value (s_fill_value),
        .s_read_col   (s_read_col),
        .s_read_row   (s_read_row),
        .queue_full   (full),
        .init_busy    (init_busy),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // command queue
    tsf_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .avail    (avail)
    );

    // shared divider
    tsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // back: fill engine and grid
    tsf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_avail    (avail),
        .cmd_in       (pop_cmd),
        .cmd_pop      (pop),
        .init_busy    (init_busy),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_value (m_cell_value)
    );

endmodule
